[rtl/ipl_pkg.sv]
// Shared types, constants and helper functions for the IP prefix list matcher.
package ipl_pkg;

  localparam int MAX_NETWORKS_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_W            = 5;
  localparam int ADDR_W           = 128;
  localparam int PREFIX_W         = 8;

  localparam logic [PREFIX_W:0]   V4_PREFIX_OFFSET = 9'd96;
  localparam logic [PREFIX_W:0]   FULL_PREFIX      = 9'd128;
  localparam logic [15:0]         V4_MAPPED_MARK   = 16'hffff;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic        addr_is_v4;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  mask_len;
    logic [3:0]  entry_index;
  } ipl_req_t;

  typedef struct packed {
    logic matched;
    logic load_done;
  } ipl_rsp_t;

  typedef struct packed {
    logic                is_load;
    logic                wr_ok;
    logic [3:0]          idx;
    logic [PREFIX_W-1:0] prefix;
    logic [ADDR_W-1:0]   addr;
  } ipl_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [PREFIX_W-1:0] prefix;
  } ipl_entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ipl_state_t;

  function automatic logic [ADDR_W-1:0] form_mask(input logic [PREFIX_W-1:0] p);
    form_mask = ~({ADDR_W{1'b1}} >> p);
  endfunction

endpackage

[rtl/ipl_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module ipl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ipl_front.sv]
// Front end: accepts requests, maps IPv4 addresses and forms the queued work item.
module ipl_front #(
  parameter int MAX_NETWORKS = ipl_pkg::MAX_NETWORKS_DEF
) (
  input  ipl_pkg::ipl_req_t  req,
  output ipl_pkg::ipl_item_t item
);

  logic [ipl_pkg::ADDR_W-1:0]   addr;
  logic [ipl_pkg::PREFIX_W:0]   p_sum;
  logic [ipl_pkg::PREFIX_W-1:0] p_sat;
  logic                         is_load;

  always_comb begin
    if (req.addr_is_v4) begin
      addr  = {64'd0, 16'd0, ipl_pkg::V4_MAPPED_MARK, req.addr_lo[31:0]};
      p_sum = {1'b0, req.mask_len} + ipl_pkg::V4_PREFIX_OFFSET;
    end else begin
      addr  = {req.addr_hi, req.addr_lo};
      p_sum = {1'b0, req.mask_len};
    end
    if (p_sum > ipl_pkg::FULL_PREFIX) begin
      p_sat = ipl_pkg::FULL_PREFIX[ipl_pkg::PREFIX_W-1:0];
    end else begin
      p_sat = p_sum[ipl_pkg::PREFIX_W-1:0];
    end
    is_load = (req.req_type == ipl_pkg::REQ_LOAD);

    item.is_load = is_load;
    item.wr_ok   = (32'(req.entry_index) < MAX_NETWORKS);
    item.idx     = req.entry_index;
    item.prefix  = p_sat;
    if (is_load) begin
      item.addr = addr & ipl_pkg::form_mask(p_sat);
    end else begin
      item.addr = addr;
    end
  end

endmodule

[rtl/ipl_fifo.sv]
// Short queue of work items between the front end and the table engine.
module ipl_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ipl_pkg::ipl_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output ipl_pkg::ipl_item_t pop_item
);

  localparam int DEPTH = ipl_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  ipl_pkg::ipl_item_t slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count exceeds depth");
`endif

endmodule

[rtl/ipl_back.sv]
// Back end: writes table entries and scans active entries for a lookup.
module ipl_back #(
  parameter int MAX_NETWORKS = ipl_pkg::MAX_NETWORKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  ipl_pkg::ipl_item_t        q_item,
  output logic                      q_pop,
  input  logic [ipl_pkg::CFG_W-1:0] active_entries,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output ipl_pkg::ipl_rsp_t         rsp
);

  localparam int IDX_W = (MAX_NETWORKS > 1) ? $clog2(MAX_NETWORKS) : 1;
  localparam int CNT_W = $clog2(MAX_NETWORKS + 1);
  localparam int LIM_W = (CNT_W > ipl_pkg::CFG_W) ? CNT_W : ipl_pkg::CFG_W;
  localparam int ENT_W = $bits(ipl_pkg::ipl_entry_t);

  ipl_pkg::ipl_state_t         state;
  ipl_pkg::ipl_state_t         state_next;
  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            cnt_next;
  logic [CNT_W-1:0]            lim;
  logic [CNT_W-1:0]            lim_next;
  logic [ipl_pkg::ADDR_W-1:0]  key;
  logic [ipl_pkg::ADDR_W-1:0]  key_next;
  logic                        rsp_valid_next;
  ipl_pkg::ipl_rsp_t           rsp_next;

  logic [LIM_W-1:0]            act_ext;
  logic [CNT_W-1:0]            n_lim;
  logic                        we;
  logic [IDX_W-1:0]            waddr;
  logic [IDX_W-1:0]            raddr;
  ipl_pkg::ipl_entry_t         wentry;
  logic [ENT_W-1:0]            rdata;
  ipl_pkg::ipl_entry_t         rentry;
  logic                        hit;

  ipl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_NETWORKS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign act_ext     = LIM_W'(active_entries);
  assign n_lim       = (act_ext > LIM_W'(MAX_NETWORKS)) ? CNT_W'(MAX_NETWORKS)
                                                        : CNT_W'(act_ext);
  assign waddr       = IDX_W'(q_item.idx);
  assign wentry.addr = q_item.addr;
  assign wentry.prefix = q_item.prefix;
  assign rentry      = rdata;
  assign hit         = ((key & ipl_pkg::form_mask(rentry.prefix)) == rentry.addr);
  assign raddr       = (state == ipl_pkg::ST_SCAN) ? cnt[IDX_W-1:0] : '0;
  assign q_pop       = q_valid && (state == ipl_pkg::ST_IDLE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipl_pkg::ST_IDLE;
      cnt       <= '0;
      lim       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      lim       <= lim_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    rsp <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    lim_next       = lim;
    key_next       = key;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    we             = 1'b0;
    case (state)
      ipl_pkg::ST_IDLE: begin
        if (q_pop) begin
          if (q_item.is_load) begin
            we                 = q_item.wr_ok;
            rsp_valid_next     = 1'b1;
            rsp_next.matched   = 1'b0;
            rsp_next.load_done = 1'b1;
          end else if (n_lim == '0) begin
            rsp_valid_next     = 1'b1;
            rsp_next.matched   = 1'b0;
            rsp_next.load_done = 1'b0;
          end else begin
            key_next   = q_item.addr;
            lim_next   = n_lim;
            cnt_next   = CNT_W'(1);
            state_next = ipl_pkg::ST_SCAN;
          end
        end
      end
      ipl_pkg::ST_SCAN: begin
        if (hit || (cnt == lim)) begin
          rsp_valid_next     = 1'b1;
          rsp_next.matched   = hit;
          rsp_next.load_done = 1'b0;
          state_next         = ipl_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = ipl_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ipl_pkg::ST_SCAN) |-> (cnt <= lim) && (cnt != '0))
    else $error("scan counter outside the active range");

  a_scan_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ipl_pkg::ST_SCAN) |-> !rsp_valid)
    else $error("result slot occupied during a scan");

  a_load_ack: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(q_pop) && $past(q_item.is_load)) |-> rsp_valid && rsp.load_done)
    else $error("load request not acknowledged on the next cycle");
`endif

endmodule

[rtl/ip_prefix_list_match.sv]
// Top level of the IP prefix list matcher: configuration register, front end, queue, back end.
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  ipl_req_t
//  rsp      out        rsp_valid/rsp_stall  ipl_rsp_t
//  cfg      in         cfg_we               cfg_data (active entry count)
//
// A request is written into the queue, and the table engine takes it from there while idle
// and not holding a stalled response. A load is then acknowledged; a lookup examines table
// entries up to the active count, stopping at the first hit, as the single registered table
// read port is walked one entry a cycle. The queue holds two requests, so req_stall rises
// once both wait behind a stalled response register. Reset is synchronous and clears the
// active count to zero; table contents are undefined until loaded.
module ip_prefix_list_match #(
  parameter int MAX_NETWORKS = ipl_pkg::MAX_NETWORKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ipl_pkg::CFG_W-1:0] cfg_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  ipl_pkg::ipl_req_t         req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output ipl_pkg::ipl_rsp_t         rsp
);

  logic [ipl_pkg::CFG_W-1:0] active_entries;
  ipl_pkg::ipl_item_t        front_item;
  ipl_pkg::ipl_item_t        q_item;
  logic                      q_full;
  logic                      q_valid;
  logic                      q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= '0;
    end else if (cfg_we) begin
      active_entries <= cfg_data;
    end
  end

  assign req_stall = q_full;

  ipl_front #(
    .MAX_NETWORKS (MAX_NETWORKS)
  ) u_front (
    .req  (req),
    .item (front_item)
  );

  ipl_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  ipl_back #(
    .MAX_NETWORKS (MAX_NETWORKS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .active_entries (active_entries),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp)
  );

endmodule

[verif/tb_ip_prefix_list_match.sv]
// Self-checking testbench for the IP prefix list matcher, with directed and random requests.
module tb_ip_prefix_list_match;
  import ipl_pkg::*;

  localparam int NET_SLOTS = MAX_NETWORKS_DEF;
  localparam int DRAIN_CYCLES = NET_SLOTS + 8;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 72;
  localparam logic [127:0] V4_BASE = {80'h0, V4_MAPPED_MARK, 32'h0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  ipl_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ipl_rsp_t rsp;

  ipl_req_t req_pending[$];
  ipl_rsp_t rsp_expected[$];

  logic [127:0] net_addr_model[NET_SLOTS];
  int unsigned net_pfx_model[NET_SLOTS];
  int unsigned active_model = 0;

  logic [127:0] net_addr_plan[NET_SLOTS];
  int unsigned net_pfx_plan[NET_SLOTS];
  int unsigned active_plan = 0;

  bit req_taken = 1'b0;
  bit steady = 1'b0;
  bit hold_go = 1'b0;
  bit rx_hold = 1'b0;
  int unsigned err_count = 0;
  int unsigned load_count = 0;
  int unsigned lookup_count = 0;
  int unsigned hit_count = 0;
  int unsigned cfg_count = 0;

  ip_prefix_list_match u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [127:0] full_address(ipl_req_t r);
    if (r.addr_is_v4) return V4_BASE | {96'h0, r.addr_lo[31:0]};
    return {r.addr_hi, r.addr_lo};
  endfunction

  function automatic logic [127:0] prefix_mask(int unsigned p);
    logic [127:0] m;
    for (int b = 0; b < 128; b++) m[127 - b] = (b < p);
    return m;
  endfunction

  function automatic int unsigned stored_prefix(ipl_req_t r);
    int unsigned p;
    p = 32'(r.mask_len) + (r.addr_is_v4 ? 96 : 0);
    return (p > 128) ? 128 : p;
  endfunction

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic ipl_rsp_t apply_request(ipl_req_t r);
    ipl_rsp_t o;
    logic [127:0] a;
    int unsigned n;
    o = '0;
    a = full_address(r);
    if (r.req_type == REQ_LOAD) begin
      net_pfx_model[r.entry_index] = stored_prefix(r);
      net_addr_model[r.entry_index] = a & prefix_mask(stored_prefix(r));
      o.load_done = 1'b1;
    end else begin
      n = (active_model > NET_SLOTS) ? NET_SLOTS : active_model;
      for (int i = 0; i < n; i++) begin
        if ((a & prefix_mask(net_pfx_model[i])) == net_addr_model[i]) o.matched = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic ipl_req_t net_req(logic kind, logic v4, logic [63:0] hi, logic [63:0] lo,
                                       logic [7:0] pfx, logic [3:0] slot);
    ipl_req_t r;
    r.req_type = kind;
    r.addr_is_v4 = v4;
    r.addr_hi = hi;
    r.addr_lo = lo;
    r.mask_len = pfx;
    r.entry_index = slot;
    return r;
  endfunction

  function automatic ipl_req_t rand_load();
    ipl_req_t r;
    int unsigned pick;
    r.req_type = REQ_LOAD;
    r.addr_is_v4 = ($urandom_range(99) < 40);
    r.addr_hi = {$urandom, $urandom};
    r.addr_lo = {$urandom, $urandom};
    r.entry_index = 4'($urandom_range(NET_SLOTS - 1));
    pick = $urandom_range(99);
    if (pick < 20) begin
      case ($urandom_range(7))
        0: r.mask_len = 8'd0;
        1: r.mask_len = 8'd1;
        2: r.mask_len = 8'd32;
        3: r.mask_len = 8'd63;
        4: r.mask_len = 8'd64;
        5: r.mask_len = 8'd65;
        6: r.mask_len = 8'd127;
        default: r.mask_len = 8'd128;
      endcase
    end else if (r.addr_is_v4 && pick < 80) begin
      r.mask_len = 8'($urandom_range(32));
    end else begin
      r.mask_len = 8'($urandom_range(128));
    end
    return r;
  endfunction

  function automatic ipl_req_t rand_lookup();
    ipl_req_t r;
    logic [127:0] a;
    int unsigned slot;
    int unsigned p;
    int unsigned n;
    int unsigned k;
    r.req_type = REQ_LOOKUP;
    r.mask_len = 8'($urandom_range(128));
    r.entry_index = 4'($urandom_range(NET_SLOTS - 1));
    n = (active_plan > NET_SLOTS) ? NET_SLOTS : active_plan;
    if ($urandom_range(99) < 20) begin
      a = rand128();
      if ($urandom_range(1) == 1) a = V4_BASE | {96'h0, a[31:0]};
    end else begin
      slot = (n == 0) ? $urandom_range(NET_SLOTS - 1) : $urandom_range(n - 1);
      p = net_pfx_plan[slot];
      a = net_addr_plan[slot] | (rand128() & ~prefix_mask(p));
      if (p != 0 && $urandom_range(99) < 30) begin
        k = 127 - $urandom_range(p - 1);
        a[k] = ~a[k];
      end
    end
    if (a[127:32] == V4_BASE[127:32] && $urandom_range(99) < 60) begin
      r.addr_is_v4 = 1'b1;
      r.addr_hi = {$urandom, $urandom};
      r.addr_lo = {$urandom, a[31:0]};
    end else begin
      r.addr_is_v4 = 1'b0;
      r.addr_hi = a[127:64];
      r.addr_lo = a[63:0];
    end
    return r;
  endfunction

  task automatic plan_request(ipl_req_t r);
    if (r.req_type == REQ_LOAD) begin
      net_pfx_plan[r.entry_index] = stored_prefix(r);
      net_addr_plan[r.entry_index] = full_address(r) & prefix_mask(stored_prefix(r));
    end
    req_pending.push_back(r);
  endtask

  task automatic wait_drained();
    while (req_pending.size() != 0 || rsp_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_active(int unsigned v);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    active_plan = v;
    cfg_count++;
  endtask

  task automatic report_mismatch(string what);
    err_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Requests are predicted in the order the block accepts them.
  always @(posedge clk) begin : req_accept
    ipl_rsp_t r;
    req_taken = 1'b0;
    if (!rst) begin
      if (cfg_we) active_model = 32'(cfg_data);
      if (req_valid && !req_stall) begin
        req_taken = 1'b1;
        r = apply_request(req);
        rsp_expected.push_back(r);
        void'(req_pending.pop_front());
        if (req.req_type == REQ_LOAD) load_count++;
        else lookup_count++;
        if (r.matched) hit_count++;
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    ipl_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_expected.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = rsp_expected.pop_front();
        if (rsp.matched !== want.matched)
          report_mismatch($sformatf("matched %b, expected %b", rsp.matched, want.matched));
        if (rsp.load_done !== want.load_done)
          report_mismatch($sformatf("load_done %b, expected %b", rsp.load_done, want.load_done));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (req_pending.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
        req_valid <= 1'b1;
        req <= req_pending[0];
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_stall <= rx_hold || (!steady && $urandom_range(99) < 24);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_sizes[9];
    ipl_req_t ld;
    phase_sizes = '{8, 16, 1, 31, 5, 0, 17, 12, 24};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With no active entries nothing can match.
    plan_request(net_req(REQ_LOOKUP, 1'b1, '1, 64'h0, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b0, '1, '1, 8'd128, 4'd15));

    plan_request(net_req(REQ_LOAD, 1'b1, '1, 64'hffffffff_0a000000, 8'd8, 4'd0));
    plan_request(net_req(REQ_LOAD, 1'b0, 64'h20010db8_deadbeef, 64'h1234, 8'd32, 4'd1));
    plan_request(net_req(REQ_LOAD, 1'b1, 64'h0, 64'h0000ffff_c0a8014d, 8'd128, 4'd2));
    plan_request(net_req(REQ_LOAD, 1'b0, '1, '1, 8'd128, 4'd3));
    plan_request(net_req(REQ_LOAD, 1'b1, {$urandom, $urandom}, {$urandom, 32'hac100000},
                         8'd12, 4'd4));
    plan_request(net_req(REQ_LOAD, 1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                         8'd65, 4'd5));
    plan_request(net_req(REQ_LOAD, 1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                         8'd127, 4'd6));
    plan_request(net_req(REQ_LOAD, 1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                         8'd0, 4'd7));
    set_active(7);

    plan_request(net_req(REQ_LOOKUP, 1'b1, '1, 64'hffffffff_0aff0102, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b1, 64'h0, 64'h0b000000, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b0, 64'h0, 64'h0000ffff_0a010203, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b0, 64'h20010db8_ffffffff, '1, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b0, 64'h20010db9_00000000, 64'h0, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b1, 64'h0, 64'hc0a8014d, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b1, 64'h0, 64'hc0a8014e, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b0, '1, '1, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b0, '1, 64'hffffffff_fffffffe, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b0, net_addr_plan[5][127:64],
                         net_addr_plan[5][63:0] | 64'h7fffffff_ffffffff, 8'd0, 4'd0));
    plan_request(net_req(REQ_LOOKUP, 1'b1, 64'h0, 64'hac1f0001, 8'd0, 4'd0));

    for (int ph = 0; ph < 9; ph++) begin
      set_active(phase_sizes[ph]);
      steady = (ph == 3);
      if (ph == 1) hold_go = 1'b1;
      // The first random phase refills slot 7 and fills the upper slots before they become active.
      if (ph == 0) begin
        for (int s = 7; s < NET_SLOTS; s++) begin
          ld = rand_load();
          ld.entry_index = 4'(s);
          plan_request(ld);
        end
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        plan_request(($urandom_range(99) < 35) ? rand_load() : rand_lookup());
      end
    end

    wait_drained();
    $display("Covered %0d loads and %0d lookups (%0d matched) over %0d active-count settings.",
             load_count, lookup_count, hit_count, cfg_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
